### rtl/core/k_nearest_point_average_defines.svh
// ----------------------------------------------------------------------------
// k_nearest_point_average assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_POINT_AVERAGE_DEFINES_SVH
`define K_NEAREST_POINT_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KNPA_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("knpa assertion failed");

// next-cycle implication
`define KNPA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("knpa assertion failed");

`else

`define KNPA_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define KNPA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

### rtl/core/knpa_pkg.sv
// ----------------------------------------------------------------------------
// knpa_pkg
// Shared types and constants of the k-nearest point average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package knpa_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 34;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LANES      = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_X = 2'd0,
        CFG_QUERY_Y = 2'd1,
        CFG_QUERY_Z = 2'd2,
        CFG_LIMIT   = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIST,
        ST_ADD,
        ST_SCAN,
        ST_REPLACE,
        ST_FINISH,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic calc_sq;
        logic calc_dist;
        logic add_entry;
        logic scan_step;
        logic replace;
        logic finish;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_present;
        logic in_last;
        logic below_limit;
        logic scan_last;
        logic count_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/core/knpa_point_if.sv
// ----------------------------------------------------------------------------
// knpa_point_if
// Valid/ready channel carrying one cloud point word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface knpa_point_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               point_present;
    logic               last_point;

    modport source (
        output valid, point_x, point_y, point_z, point_present, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, point_present, last_point,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/knpa_mean_if.sv
// ----------------------------------------------------------------------------
// knpa_mean_if
// Valid/ready channel carrying one mean result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface knpa_mean_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic               used_fallback;

    modport source (
        output valid, mean_x, mean_y, mean_z, used_fallback,
        input  ready
    );

    modport sink (
        input  valid, mean_x, mean_y, mean_z, used_fallback,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/knpa_divider.sv
// ----------------------------------------------------------------------------
// knpa_divider
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_nearest_point_average_defines.svh"

module knpa_divider
    import knpa_pkg::*;
#(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [LANES-1:0][SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]            i_divisor,
    output logic [LANES-1:0][SUM_W-1:0] o_quotient,
    output logic                        o_done
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [CNT_W-1:0]            r_divisor;
    logic [LANES-1:0][SUM_W-1:0] r_quo;
    logic [LANES-1:0][CNT_W-1:0] r_rem;
    logic [LANES-1:0][SUM_W-1:0] n_quo;
    logic [LANES-1:0][CNT_W-1:0] n_rem;

    always_comb begin
        logic [CNT_W:0] rem_sh;
        logic           ge;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int l = 0; l < LANES; l++) begin
            rem_sh   = {r_rem[l], r_quo[l][SUM_W-1]};
            ge       = rem_sh >= {1'b0, r_divisor};
            n_rem[l] = ge ? CNT_W'(rem_sh - {1'b0, r_divisor}) : CNT_W'(rem_sh);
            n_quo[l] = {r_quo[l][SUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    `KNPA_ASSERT_NEXT(a_done_after_last_step, i_clk, i_rst_n, r_busy && !i_start && r_step == LAST_STEP, o_done && !r_busy)

endmodule

`default_nettype wire

### rtl/core/knpa_datapath.sv
// ----------------------------------------------------------------------------
// knpa_datapath
// Distance pipeline, kept-entry registers, worst-entry scan, running sums,
// divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_nearest_point_average_defines.svh"

module knpa_datapath
    import knpa_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 8,
    parameter int ARRIVAL_BITS  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    knpa_point_if.sink            i_point,
    knpa_mean_if.source           o_mean,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status
);

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SUM_W = COORD_W + $clog2(MAX_NEIGHBORS);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // configuration
    logic signed [COORD_W-1:0] r_query_x, r_query_y, r_query_z;
    logic [LIMIT_W-1:0]        r_limit;

    // current point and distance pipeline
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]           r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]         r_dist;

    // kept entries
    logic [DIST_W-1:0]         r_kd [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] r_kx [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] r_ky [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] r_kz [MAX_NEIGHBORS];
    logic [ARRIVAL_BITS-1:0]   r_ka [MAX_NEIGHBORS];
    logic [CNT_W-1:0]          r_count;
    logic [ARRIVAL_BITS-1:0]   r_arrival;

    // worst-entry scan
    logic [IDX_W-1:0]          r_scan_idx;
    logic [IDX_W-1:0]          r_widx;
    logic [DIST_W-1:0]         r_wd;
    logic [ARRIVAL_BITS-1:0]   r_wa;
    logic signed [COORD_W-1:0] r_wx, r_wy, r_wz;

    // sums, result
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y, r_sum_z;
    logic [LANES-1:0]          r_neg;
    logic                      r_fallback;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                      r_out_fb;

    logic                        load;
    logic signed [2*DIFF_W-1:0]  prod_x, prod_y, prod_z;
    logic [CMP_W-1:0]            lim_ext, eff_limit;
    logic                        below_limit;
    logic                        scan_last;
    logic                        count_zero;
    logic                        take;
    logic                        replace_hit;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;
    logic signed [SUM_W-1:0]     px_ext, py_ext, pz_ext;
    logic signed [SUM_W-1:0]     wx_ext, wy_ext, wz_ext;
    logic [LANES-1:0][SUM_W-1:0] mag;
    logic [LANES-1:0][SUM_W-1:0] quo;
    logic [LANES-1:0][SUM_W-1:0] signed_quo;
    logic                        div_done;

    assign load = i_cmd.in_ready && i_point.valid;

    // limit of 0 acts as 1, anything above the storage depth saturates
    assign lim_ext     = CMP_W'(r_limit);
    assign eff_limit   = (lim_ext == '0) ? CMP_W'(1) :
                         (lim_ext > CMP_W'(MAX_NEIGHBORS)) ? CMP_W'(MAX_NEIGHBORS) : lim_ext;
    assign below_limit = CMP_W'(r_count) < eff_limit;
    assign count_zero  = r_count == '0;
    assign scan_last   = CNT_W'(r_scan_idx) == (r_count - CNT_W'(1));

    // worse: farther, or equally far and arrived later
    assign take = (r_scan_idx == '0) ||
                  (r_kd[r_scan_idx] > r_wd) ||
                  ((r_kd[r_scan_idx] == r_wd) && (r_ka[r_scan_idx] > r_wa));

    assign replace_hit = i_cmd.replace && (r_dist < r_wd);
    assign wr_en       = i_cmd.add_entry || replace_hit;
    assign wr_idx      = i_cmd.add_entry ? r_count[IDX_W-1:0] : r_widx;

    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;
    assign prod_z = r_dz * r_dz;

    assign px_ext = SUM_W'(r_px);
    assign py_ext = SUM_W'(r_py);
    assign pz_ext = SUM_W'(r_pz);
    assign wx_ext = SUM_W'(r_wx);
    assign wy_ext = SUM_W'(r_wy);
    assign wz_ext = SUM_W'(r_wz);

    assign mag[0] = r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
    assign mag[1] = r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);
    assign mag[2] = r_sum_z[SUM_W-1] ? SUM_W'(-r_sum_z) : SUM_W'(r_sum_z);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            signed_quo[l] = r_neg[l] ? SUM_W'(-quo[l]) : quo[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
            r_query_z <= '0;
            r_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_QUERY_X: r_query_x <= i_cfg_data;
                CFG_QUERY_Y: r_query_y <= i_cfg_data;
                CFG_QUERY_Z: r_query_z <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px <= i_point.point_x;
            r_py <= i_point.point_y;
            r_pz <= i_point.point_z;
            r_dx <= DIFF_W'(i_point.point_x) - DIFF_W'(r_query_x);
            r_dy <= DIFF_W'(i_point.point_y) - DIFF_W'(r_query_y);
            r_dz <= DIFF_W'(i_point.point_z) - DIFF_W'(r_query_z);
        end
        if (i_cmd.calc_sq) begin
            r_sqx <= prod_x[SQ_W-1:0];
            r_sqy <= prod_y[SQ_W-1:0];
            r_sqz <= prod_z[SQ_W-1:0];
        end
        if (i_cmd.calc_dist) begin
            r_dist <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_kd[wr_idx] <= r_dist;
            r_kx[wr_idx] <= r_px;
            r_ky[wr_idx] <= r_py;
            r_kz[wr_idx] <= r_pz;
            r_ka[wr_idx] <= r_arrival;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_arrival <= '0;
        end else if (i_cmd.finish) begin
            r_count   <= '0;
            r_arrival <= '0;
        end else begin
            if (i_cmd.add_entry) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.add_entry || i_cmd.replace) begin
                r_arrival <= r_arrival + ARRIVAL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_dist) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            if (take) begin
                r_widx <= r_scan_idx;
                r_wd   <= r_kd[r_scan_idx];
                r_wa   <= r_ka[r_scan_idx];
                r_wx   <= r_kx[r_scan_idx];
                r_wy   <= r_ky[r_scan_idx];
                r_wz   <= r_kz[r_scan_idx];
            end
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
    end

    // running sums; the first entry of a cloud restarts them
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_entry) begin
            r_sum_x <= count_zero ? px_ext : r_sum_x + px_ext;
            r_sum_y <= count_zero ? py_ext : r_sum_y + py_ext;
            r_sum_z <= count_zero ? pz_ext : r_sum_z + pz_ext;
        end else if (replace_hit) begin
            r_sum_x <= r_sum_x + px_ext - wx_ext;
            r_sum_y <= r_sum_y + py_ext - wy_ext;
            r_sum_z <= r_sum_z + pz_ext - wz_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fallback <= count_zero;
            r_neg      <= {r_sum_z[SUM_W-1], r_sum_y[SUM_W-1], r_sum_x[SUM_W-1]};
        end
    end

    knpa_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.finish && !count_zero),
        .i_dividend (mag),
        .i_divisor  (r_count),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_mean.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_fb <= r_fallback;
            r_out_x  <= r_fallback ? r_query_x : signed_quo[0][COORD_W-1:0];
            r_out_y  <= r_fallback ? r_query_y : signed_quo[1][COORD_W-1:0];
            r_out_z  <= r_fallback ? r_query_z : signed_quo[2][COORD_W-1:0];
        end
    end

    assign i_point.ready        = i_cmd.in_ready;
    assign o_mean.valid         = r_out_valid;
    assign o_mean.mean_x        = r_out_x;
    assign o_mean.mean_y        = r_out_y;
    assign o_mean.mean_z        = r_out_z;
    assign o_mean.used_fallback = r_out_fb;

    assign o_status.in_valid    = i_point.valid;
    assign o_status.in_present  = i_point.point_present;
    assign o_status.in_last     = i_point.last_point;
    assign o_status.below_limit = below_limit;
    assign o_status.scan_last   = scan_last;
    assign o_status.count_zero  = count_zero;
    assign o_status.div_done    = div_done;
    assign o_status.out_free    = !r_out_valid || o_mean.ready;

    `KNPA_ASSERT_IMPLY(a_add_only_below_limit, i_clk, i_rst_n, i_cmd.add_entry, below_limit && !i_cmd.replace)
    `KNPA_ASSERT_NEXT(a_finish_clears_cloud, i_clk, i_rst_n, i_cmd.finish, r_count == '0 && r_arrival == '0)

endmodule

`default_nettype wire

### rtl/core/knpa_ctrl.sv
// ----------------------------------------------------------------------------
// knpa_ctrl
// Sequencer: accept, distance, add or scan-and-replace, finish, divide, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_nearest_point_average_defines.svh"

module knpa_ctrl
    import knpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    n_last = i_status.in_last;
                    priority if (i_status.in_present) begin
                        n_state = ST_SQUARE;
                    end else if (i_status.in_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        // word without a point in mid-cloud: nothing to do
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SQUARE: begin
                o_cmd.calc_sq = 1'b1;
                n_state       = ST_DIST;
            end
            ST_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_state         = i_status.below_limit ? ST_ADD : ST_SCAN;
            end
            ST_ADD: begin
                o_cmd.add_entry = 1'b1;
                n_state         = r_last ? ST_FINISH : ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_REPLACE;
                end
            end
            ST_REPLACE: begin
                o_cmd.replace = 1'b1;
                n_state       = r_last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = i_status.count_zero ? ST_EMIT : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `KNPA_ASSERT_NEXT(a_divide_done_to_emit, i_clk, i_rst_n, r_state == ST_DIVIDE && i_status.div_done, r_state == ST_EMIT)
    `KNPA_ASSERT_NEXT(a_empty_last_to_finish, i_clk, i_rst_n, o_cmd.in_ready && i_status.in_valid && !i_status.in_present && i_status.in_last, r_state == ST_FINISH)

endmodule

`default_nettype wire

### rtl/core/k_nearest_point_average.sv
// ----------------------------------------------------------------------------
// k_nearest_point_average
// Mean of the k points of a streamed cloud nearest to a configured query.
// ----------------------------------------------------------------------------
// One point word at a time. A word without a point is taken in the idle
// state alone. While fewer than the limit are kept, a point passes capture,
// square, distance sum and store; once the kept set is full, the store is
// replaced by a scan over the kept entries, one per cycle, to find the worst,
// and a replace step. A last word adds a finish step, then a restoring
// divider of one quotient bit per cycle runs, and the output register is
// loaded once it is free; an empty cloud skips the divider. The result word
// sits in its own output register, so the next cloud starts while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_nearest_point_average
    import knpa_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 8,
    parameter int ARRIVAL_BITS  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    knpa_point_if.sink            i_point,
    knpa_mean_if.source           o_mean
);

    t_dp_cmd    cmd;
    t_dp_status status;

    knpa_datapath #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .ARRIVAL_BITS  (ARRIVAL_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     (i_point),
        .o_mean      (o_mean),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    knpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

endmodule

`default_nettype wire
